@@ design/cross_average_smudge_unit_defines.svh @@
`ifndef CROSS_AVERAGE_SMUDGE_UNIT_DEFINES_SVH
`define CROSS_AVERAGE_SMUDGE_UNIT_DEFINES_SVH

// Check a property at every clock edge outside reset.
`define CSM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property at every clock edge, reset included.
`define CSM_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ design/csm_pkg.sv @@
package csm_pkg;

   localparam int MAX_WIDTH   = 2048;
   localparam int MAX_HEIGHT  = 2048;
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int ROW_W       = $clog2(MAX_HEIGHT);
   localparam int SIZE_W      = 12;
   localparam int CHAN_W      = 8;
   localparam int NUM_CHAN    = 4;
   localparam int PIX_W       = CHAN_W * NUM_CHAN;
   localparam int FILTER_TAPS = 5;
   localparam int SUM_W       = $clog2(FILTER_TAPS * (2**CHAN_W - 1) + 1);
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int ADDR_W      = 3;
   localparam int DATA_W      = 32;

   // Reciprocal of the tap count, rounded up; exact for every reachable sum.
   localparam int DIV_SHIFT   = 14;
   localparam int DIV_MUL     = (2**DIV_SHIFT + FILTER_TAPS - 1) / FILTER_TAPS;
   localparam int DIV_MUL_W   = $clog2(DIV_MUL + 1);
   localparam int PROD_W      = SUM_W + DIV_MUL_W;

   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_DRAIN = 1'b1;

   localparam logic [SIZE_W-1:0] FRAME_WIDTH_RESET  = SIZE_W'(640);
   localparam logic [SIZE_W-1:0] FRAME_HEIGHT_RESET = SIZE_W'(480);

   typedef enum logic [ADDR_W-3:0] {
      REG_FRAME_WIDTH  = 1'b0,
      REG_FRAME_HEIGHT = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic                               filter;
      logic                               last;
      logic [NUM_CHAN-1:0][SUM_W-1:0]     sum;
   } entry_type;

   typedef struct packed {
      logic      push;
      entry_type entry;
   } push_type;

   function automatic logic [CHAN_W-1:0] mean_of_taps(input logic [SUM_W-1:0] s);
      logic [PROD_W-1:0] prod;
      prod = PROD_W'(s) * PROD_W'(DIV_MUL);
      return prod[DIV_SHIFT +: CHAN_W];
   endfunction

endpackage

@@ design/csm_ram.sv @@
module csm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Read-first: a read of the address written in the same cycle gives the old word.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/csm_front.sv @@
module csm_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [csm_pkg::SIZE_W-1:0]    frame_width,
   input  logic [csm_pkg::SIZE_W-1:0]    frame_height,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_cmd,
   input  logic [csm_pkg::PIX_W-1:0]     req_pixel,
   input  logic [csm_pkg::QPTR_W:0]      queue_count,
   output csm_pkg::push_type             push
);

   import csm_pkg::*;

   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] drain_ff, drain_in;
   logic             await_ff, await_in;

   logic [COL_W:0]   width;
   logic [ROW_W:0]   height;
   logic [COL_W-1:0] col_c;
   logic [ROW_W-1:0] row_c;
   logic [COL_W-1:0] drain_c;
   logic [COL_W:0]   col_next;
   logic [ROW_W:0]   row_next;
   logic [COL_W:0]   drain_next;
   logic             last_col, last_row, last_drain;

   logic             accept, is_drain;
   logic             a_push, a_filter, a_last, a_pixel;
   logic [COL_W-1:0] center_addr;

   logic             b_push_ff, b_pixel_ff;
   logic             b_filter_ff, b_last_ff;
   logic [COL_W-1:0] b_col_ff;
   logic [PIX_W-1:0] b_down_ff;
   logic [PIX_W-1:0] left_ff;

   logic [PIX_W-1:0] center, right, up;

   // Sizes used saturated to the line store range
   always_comb begin
      if (frame_width == '0) begin
         width = (COL_W+1)'(1);
      end else if (32'(frame_width) > MAX_WIDTH) begin
         width = (COL_W+1)'(MAX_WIDTH);
      end else begin
         width = (COL_W+1)'(frame_width);
      end
      if (frame_height == '0) begin
         height = (ROW_W+1)'(1);
      end else if (32'(frame_height) > MAX_HEIGHT) begin
         height = (ROW_W+1)'(MAX_HEIGHT);
      end else begin
         height = (ROW_W+1)'(frame_height);
      end
   end

   // A counter at or beyond the last place counts as being on it
   always_comb begin
      col_c      = ((COL_W+1)'(col_ff) >= width) ? COL_W'(width - 1'b1) : col_ff;
      row_c      = ((ROW_W+1)'(row_ff) >= height) ? ROW_W'(height - 1'b1) : row_ff;
      drain_c    = ((COL_W+1)'(drain_ff) >= width) ? COL_W'(width - 1'b1) : drain_ff;
      col_next   = (COL_W+1)'(col_c) + (COL_W+1)'(1);
      row_next   = (ROW_W+1)'(row_c) + (ROW_W+1)'(1);
      drain_next = (COL_W+1)'(drain_c) + (COL_W+1)'(1);
      last_col   = col_next >= width;
      last_row   = row_next >= height;
      last_drain = drain_next >= width;
   end

   assign req_ready = ((QPTR_W+2)'(queue_count) + (QPTR_W+2)'(b_push_ff))
                      < (QPTR_W+2)'(QUEUE_DEPTH);
   assign accept    = req_valid && req_ready;
   assign is_drain  = req_cmd == CMD_DRAIN;

   always_comb begin
      col_in      = col_ff;
      row_in      = row_ff;
      drain_in    = drain_ff;
      await_in    = await_ff;
      a_push      = 1'b0;
      a_filter    = 1'b0;
      a_last      = 1'b0;
      a_pixel     = 1'b0;
      center_addr = is_drain ? drain_c : col_c;
      if (accept) begin
         if (is_drain) begin
            // drop a drain transaction until the frame is complete
            if (await_ff) begin
               a_push = 1'b1;
               if (last_drain) begin
                  a_last   = 1'b1;
                  drain_in = '0;
                  col_in   = '0;
                  row_in   = '0;
                  await_in = 1'b0;
               end else begin
                  drain_in = COL_W'(drain_next);
               end
            end
         end else if (!await_ff) begin
            a_pixel = 1'b1;
            row_in  = row_c;
            if (row_c != '0) begin
               a_push   = 1'b1;
               a_filter = !(row_c == ROW_W'(1) || col_c == '0 || last_col);
            end
            if (last_col) begin
               col_in = '0;
               if (last_row) begin
                  await_in = 1'b1;
                  drain_in = '0;
               end else begin
                  row_in = ROW_W'(row_next);
               end
            end else begin
               col_in = COL_W'(col_next);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         drain_ff   <= '0;
         await_ff   <= 1'b0;
         b_push_ff  <= 1'b0;
         b_pixel_ff <= 1'b0;
      end else begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         drain_ff   <= drain_in;
         await_ff   <= await_in;
         b_push_ff  <= a_push;
         b_pixel_ff <= a_pixel;
      end
   end

   always_ff @(posedge clock) begin
      b_filter_ff <= a_filter;
      b_last_ff   <= a_last;
      b_col_ff    <= col_c;
      b_down_ff   <= req_pixel;
      // the centre of one pixel is the left neighbour of the next
      if (b_pixel_ff) begin
         left_ff <= center;
      end
   end

   // two copies of the previous line give the centre and the right neighbour
   csm_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle_centre (
      .clock   (clock),
      .wr_en   (a_pixel),
      .wr_addr (col_c),
      .wr_data (req_pixel),
      .rd_addr (center_addr),
      .rd_data (center)
   );

   csm_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle_right (
      .clock   (clock),
      .wr_en   (a_pixel),
      .wr_addr (col_c),
      .wr_data (req_pixel),
      .rd_addr (COL_W'(col_next)),
      .rd_data (right)
   );

   // move the old middle word up once it has been read
   csm_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
      .clock   (clock),
      .wr_en   (b_pixel_ff),
      .wr_addr (b_col_ff),
      .wr_data (center),
      .rd_addr (col_c),
      .rd_data (up)
   );

   always_comb begin
      push.push         = b_push_ff;
      push.entry.filter = b_filter_ff;
      push.entry.last   = b_last_ff;
      for (int k = 0; k < NUM_CHAN; k++) begin
         if (b_filter_ff) begin
            push.entry.sum[k] = SUM_W'(center[k*CHAN_W +: CHAN_W])
                              + SUM_W'(up[k*CHAN_W +: CHAN_W])
                              + SUM_W'(left_ff[k*CHAN_W +: CHAN_W])
                              + SUM_W'(right[k*CHAN_W +: CHAN_W])
                              + SUM_W'(b_down_ff[k*CHAN_W +: CHAN_W]);
         end else begin
            push.entry.sum[k] = SUM_W'(center[k*CHAN_W +: CHAN_W]);
         end
      end
   end

endmodule

@@ design/csm_queue.sv @@
module csm_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  csm_pkg::push_type          push,
   input  logic                       pop,
   output logic                       head_valid,
   output csm_pkg::entry_type         head,
   output logic [csm_pkg::QPTR_W:0]   count
);

   import csm_pkg::*;

   entry_type         entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push.push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push.push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.push) begin
         entries_ff[wr_ptr_ff] <= push.entry;
      end
   end

   assign head_valid = count_ff != '0;
   assign head       = entries_ff[rd_ptr_ff];
   assign count      = count_ff;

endmodule

@@ design/csm_back.sv @@
module csm_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       head_valid,
   input  csm_pkg::entry_type         head,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [csm_pkg::PIX_W-1:0]  rsp_pixel,
   output logic                       rsp_last
);

   import csm_pkg::*;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0] pixel_ff, pixel_in;
   logic             last_ff, last_in;
   logic [PIX_W-1:0] result;

   always_comb begin
      for (int k = 0; k < NUM_CHAN; k++) begin
         result[k*CHAN_W +: CHAN_W] = head.filter ? mean_of_taps(head.sum[k])
                                                  : head.sum[k][CHAN_W-1:0];
      end
   end

   // take the next entry when the output register is free or being drained
   always_comb begin
      pop          = head_valid && (!rsp_valid_ff || rsp_ready);
      rsp_valid_in = rsp_valid_ff;
      pixel_in     = pixel_ff;
      last_in      = last_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
         pixel_in     = result;
         last_in      = head.last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pixel_ff <= pixel_in;
      last_ff  <= last_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pixel = pixel_ff;
   assign rsp_last  = last_ff;

endmodule

@@ design/cross_average_smudge_unit.sv @@
// Five-point cross mean filter over a raster stream of RGBA pixels.
// Input channel req_*: one transaction per pixel (req_cmd pixel) or per drain
// step (req_cmd drain). Output channel rsp_*: the filtered frame in raster
// order; rsp_frame_last marks its final pixel. Border pixels pass unchanged.
// A pixel of line r leaves when the pixel below it arrives, so the output
// runs one line behind; after the last pixel of a frame, one drain
// transaction per column flushes the final line.
// A result passes the front end's push register, the queue and the
// output register to rsp_valid. Throughput: one transaction per cycle
// while req_ready is high, set by the single read and write per cycle
// of each line store. The user must write frame_width (0x0) and
// frame_height (0x4) over the APB port only while the block is idle; the
// block does not enforce this. Values outside 1..2048 are used saturated.
// Reset clears the counters, the queue and the output register and loads
// 640 x 480; the line stores are not cleared. When the receiver stalls,
// results collect in a four-entry queue; req_ready falls when about to fill.
module cross_average_smudge_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_cmd,
   input  logic [csm_pkg::CHAN_W-1:0]        req_in_red,
   input  logic [csm_pkg::CHAN_W-1:0]        req_in_green,
   input  logic [csm_pkg::CHAN_W-1:0]        req_in_blue,
   input  logic [csm_pkg::CHAN_W-1:0]        req_in_alpha,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [csm_pkg::CHAN_W-1:0]        rsp_out_red,
   output logic [csm_pkg::CHAN_W-1:0]        rsp_out_green,
   output logic [csm_pkg::CHAN_W-1:0]        rsp_out_blue,
   output logic [csm_pkg::CHAN_W-1:0]        rsp_out_alpha,
   output logic                              rsp_frame_last,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [csm_pkg::ADDR_W-1:0]        paddr,
   input  logic [csm_pkg::DATA_W-1:0]        pwdata,
   output logic [csm_pkg::DATA_W-1:0]        prdata,
   output logic                              pready
);

   import csm_pkg::*;

   logic [SIZE_W-1:0] frame_width_ff, frame_width_in;
   logic [SIZE_W-1:0] frame_height_ff, frame_height_in;
   reg_index_type     reg_index;
   logic              csr_write;

   push_type          push;
   entry_type         head;
   logic              head_valid;
   logic              pop;
   logic [QPTR_W:0]   queue_count;
   logic [PIX_W-1:0]  rsp_pixel;

   assign pready    = 1'b1;
   assign reg_index = reg_index_type'(paddr[ADDR_W-1:2]);
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (csr_write) begin
         case (reg_index)
            REG_FRAME_WIDTH:  frame_width_in  = pwdata[SIZE_W-1:0];
            REG_FRAME_HEIGHT: frame_height_in = pwdata[SIZE_W-1:0];
            default:          frame_width_in  = frame_width_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_FRAME_WIDTH:  prdata = DATA_W'(frame_width_ff);
         REG_FRAME_HEIGHT: prdata = DATA_W'(frame_height_ff);
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
      end
   end

   csm_front u_front (
      .clock        (clock),
      .reset        (reset),
      .frame_width  (frame_width_ff),
      .frame_height (frame_height_ff),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_cmd      (req_cmd),
      .req_pixel    ({req_in_alpha, req_in_blue, req_in_green, req_in_red}),
      .queue_count  (queue_count),
      .push         (push)
   );

   csm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head),
      .count      (queue_count)
   );

   csm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_pixel  (rsp_pixel),
      .rsp_last   (rsp_frame_last)
   );

   assign rsp_out_red   = rsp_pixel[0*CHAN_W +: CHAN_W];
   assign rsp_out_green = rsp_pixel[1*CHAN_W +: CHAN_W];
   assign rsp_out_blue  = rsp_pixel[2*CHAN_W +: CHAN_W];
   assign rsp_out_alpha = rsp_pixel[3*CHAN_W +: CHAN_W];

endmodule

@@ design/csm_checker.sv @@
`include "cross_average_smudge_unit_defines.svh"

module csm_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [csm_pkg::CHAN_W-1:0]        rsp_out_red,
   input logic [csm_pkg::CHAN_W-1:0]        rsp_out_green,
   input logic [csm_pkg::CHAN_W-1:0]        rsp_out_blue,
   input logic [csm_pkg::CHAN_W-1:0]        rsp_out_alpha,
   input logic                              rsp_frame_last,
   input logic                              psel,
   input logic                              penable,
   input logic                              pwrite,
   input logic [csm_pkg::ADDR_W-1:0]        paddr,
   input logic [csm_pkg::DATA_W-1:0]        pwdata,
   input logic [csm_pkg::DATA_W-1:0]        prdata
);

   import csm_pkg::*;

   // nothing comes out straight after reset
   `CSM_ASSERT(a_no_result_after_reset, $past(reset) |-> !rsp_valid, "result after reset")

   // an empty queue accepts at once
   `CSM_ASSERT(a_ready_after_reset, $past(reset) |-> req_ready, "not ready after reset")

   `CSM_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_red) && $stable(rsp_out_green) && $stable(rsp_out_blue) && $stable(rsp_out_alpha) && $stable(rsp_frame_last), "stalled result changed")

   `CSM_ASSERT(a_width_readback, (psel && penable && pwrite && paddr[ADDR_W-1:2] == REG_FRAME_WIDTH) ##1 (psel && !pwrite && paddr[ADDR_W-1:2] == REG_FRAME_WIDTH) |-> prdata[SIZE_W-1:0] == $past(pwdata[SIZE_W-1:0]), "frame width readback mismatch")

endmodule

bind cross_average_smudge_unit csm_checker u_csm_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_out_red    (rsp_out_red),
   .rsp_out_green  (rsp_out_green),
   .rsp_out_blue   (rsp_out_blue),
   .rsp_out_alpha  (rsp_out_alpha),
   .rsp_frame_last (rsp_frame_last),
   .psel           (psel),
   .penable        (penable),
   .pwrite         (pwrite),
   .paddr          (paddr),
   .pwdata         (pwdata),
   .prdata         (prdata)
);

@@ bench/tb_cross_average_smudge_unit.sv @@
module tb_cross_average_smudge_unit;
   import csm_pkg::*;

   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_ITEMS  = 700;
   localparam int NUM_EXTREMES  = 5;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] alpha;
      logic              last;
   } filtered_type;

   typedef struct packed {
      logic [SIZE_W-1:0] w;
      logic [SIZE_W-1:0] h;
      logic              cmd;
      logic [PIX_W-1:0]  pix;
      logic              typed;
      logic              gives;
      logic [PIX_W-1:0]  want;
      logic              want_last;
   } script_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic              req_cmd = CMD_PIXEL;
   logic [CHAN_W-1:0] req_in_red = '0;
   logic [CHAN_W-1:0] req_in_green = '0;
   logic [CHAN_W-1:0] req_in_blue = '0;
   logic [CHAN_W-1:0] req_in_alpha = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [CHAN_W-1:0] rsp_out_red;
   logic [CHAN_W-1:0] rsp_out_green;
   logic [CHAN_W-1:0] rsp_out_blue;
   logic [CHAN_W-1:0] rsp_out_alpha;
   logic              rsp_frame_last;
   logic              psel = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite = 1'b0;
   logic [ADDR_W-1:0] paddr = '0;
   logic [DATA_W-1:0] pwdata = '0;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   cross_average_smudge_unit i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd        (req_cmd),
      .req_in_red     (req_in_red),
      .req_in_green   (req_in_green),
      .req_in_blue    (req_in_blue),
      .req_in_alpha   (req_in_alpha),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_red    (rsp_out_red),
      .rsp_out_green  (rsp_out_green),
      .rsp_out_blue   (rsp_out_blue),
      .rsp_out_alpha  (rsp_out_alpha),
      .rsp_frame_last (rsp_frame_last),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   // Filter state mirrored by the predictor
   logic [PIX_W-1:0]  row_above [MAX_WIDTH];
   logic [PIX_W-1:0]  row_prior [MAX_WIDTH];
   int unsigned       col_at = 0;
   int unsigned       row_at = 0;
   int unsigned       drain_at = 0;
   bit                awaiting_drain = 1'b0;
   logic [SIZE_W-1:0] size_q [2];

   filtered_type      expected_pixels [$];
   int unsigned       fault_count = 0;
   int unsigned       random_items = 0;
   bit                calm = 1'b0;

   // Border pixels pass through as listed; the interior pixel is left to the predictor
   script_row_type directed_script [21] = '{
      '{12'd3, 12'd3, CMD_DRAIN, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000, 1'b0},
      '{12'd3, 12'd3, CMD_PIXEL, 32'h00ff_00ff, 1'b1, 1'b0, 32'h0000_0000, 1'b0},
      '{12'd3, 12'd3, CMD_PIXEL, 32'hff00_ff00, 1'b1, 1'b0, 32'h0000_0000, 1'b0},
      '{12'd3, 12'd3, CMD_PIXEL, 32'hffff_ffff, 1'b1, 1'b0, 32'h0000_0000, 1'b0},
      '{12'd3, 12'd3, CMD_PIXEL, 32'h0000_0000, 1'b1, 1'b1, 32'h00ff_00ff, 1'b0},
      '{12'd3, 12'd3, CMD_PIXEL, 32'h1020_4080, 1'b1, 1'b1, 32'hff00_ff00, 1'b0},
      '{12'd3, 12'd3, CMD_PIXEL, 32'h0403_0201, 1'b1, 1'b1, 32'hffff_ffff, 1'b0},
      '{12'd3, 12'd3, CMD_PIXEL, 32'h01fe_807f, 1'b1, 1'b1, 32'h0000_0000, 1'b0},
      '{12'd3, 12'd3, CMD_PIXEL, 32'hffff_ffff, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
      '{12'd3, 12'd3, CMD_PIXEL, 32'h7856_3412, 1'b1, 1'b1, 32'h0403_0201, 1'b0},
      '{12'd3, 12'd3, CMD_PIXEL, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000, 1'b0},
      '{12'd3, 12'd3, CMD_DRAIN, 32'hffff_ffff, 1'b1, 1'b1, 32'h01fe_807f, 1'b0},
      '{12'd3, 12'd3, CMD_DRAIN, 32'h0000_0000, 1'b1, 1'b1, 32'hffff_ffff, 1'b0},
      '{12'd3, 12'd3, CMD_DRAIN, 32'h0000_0000, 1'b1, 1'b1, 32'h7856_3412, 1'b1},
      '{12'd3, 12'd3, CMD_DRAIN, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000, 1'b0},
      '{12'd2, 12'd1, CMD_PIXEL, 32'hffff_ffff, 1'b1, 1'b0, 32'h0000_0000, 1'b0},
      '{12'd2, 12'd1, CMD_PIXEL, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000, 1'b0},
      '{12'd2, 12'd1, CMD_DRAIN, 32'h0000_0000, 1'b1, 1'b1, 32'hffff_ffff, 1'b0},
      '{12'd2, 12'd1, CMD_DRAIN, 32'hffff_ffff, 1'b1, 1'b1, 32'h0000_0000, 1'b1},
      '{12'd0, 12'd0, CMD_PIXEL, 32'h5a5a_a5a5, 1'b1, 1'b0, 32'h0000_0000, 1'b0},
      '{12'd0, 12'd0, CMD_DRAIN, 32'h0000_0000, 1'b1, 1'b1, 32'h5a5a_a5a5, 1'b1}
   };

   logic [SIZE_W-1:0] extreme_sizes [NUM_EXTREMES][2] = '{
      '{12'd0, 12'd4}, '{12'd4, 12'd0}, '{12'd1, 12'd1},
      '{12'd3, 12'd3}, '{12'd2, 12'd9}
   };

   function automatic int unsigned clamp_size(input logic [SIZE_W-1:0] v,
                                              input int unsigned top);
      if (v == '0) return 1;
      if (32'(v) > top) return top;
      return 32'(v);
   endfunction

   function automatic filtered_type split_pixel(input logic [PIX_W-1:0] p, input logic last);
      filtered_type r;
      r.red   = p[0*CHAN_W +: CHAN_W];
      r.green = p[1*CHAN_W +: CHAN_W];
      r.blue  = p[2*CHAN_W +: CHAN_W];
      r.alpha = p[3*CHAN_W +: CHAN_W];
      r.last  = last;
      return r;
   endfunction

   // Advance the mirrored filter by one transaction; return 1 when it yields a pixel
   function automatic bit predict_smudge(input logic cmd, input logic [PIX_W-1:0] pix,
                                         output filtered_type res);
      int unsigned      w;
      int unsigned      h;
      int unsigned      c;
      int unsigned      d;
      int unsigned      orow;
      int unsigned      total;
      logic [PIX_W-1:0] mean;
      bit               gives;
      w = clamp_size(size_q[REG_FRAME_WIDTH], MAX_WIDTH);
      h = clamp_size(size_q[REG_FRAME_HEIGHT], MAX_HEIGHT);
      res = '0;
      gives = 1'b0;
      if (cmd == CMD_DRAIN) begin
         if (awaiting_drain) begin
            d = (drain_at >= w) ? w - 1 : drain_at;
            gives = 1'b1;
            res = split_pixel(row_prior[d], d + 1 >= w);
            if (d + 1 >= w) begin
               drain_at = 0;
               col_at = 0;
               row_at = 0;
               awaiting_drain = 1'b0;
            end else begin
               drain_at = d + 1;
            end
         end
      end else if (!awaiting_drain) begin
         // a counter past a shrunk size sits on the last column or row
         c = (col_at >= w) ? w - 1 : col_at;
         if (row_at >= h) row_at = h - 1;
         if (row_at > 0) begin
            orow = row_at - 1;
            mean = row_prior[c];
            if (orow != 0 && orow + 1 < h && c != 0 && c + 1 < w) begin
               for (int k = 0; k < NUM_CHAN; k++) begin
                  // left neighbour has already moved up into the row above
                  total = 32'(row_prior[c][CHAN_W*k +: CHAN_W])
                        + 32'(row_above[c][CHAN_W*k +: CHAN_W])
                        + 32'(row_above[c-1][CHAN_W*k +: CHAN_W])
                        + 32'(row_prior[c+1][CHAN_W*k +: CHAN_W])
                        + 32'(pix[CHAN_W*k +: CHAN_W]);
                  mean[CHAN_W*k +: CHAN_W] = CHAN_W'(total / FILTER_TAPS);
               end
            end
            gives = 1'b1;
            res = split_pixel(mean, 1'b0);
         end
         row_above[c] = row_prior[c];
         row_prior[c] = pix;
         if (c + 1 >= w) begin
            col_at = 0;
            if (row_at + 1 >= h) begin
               awaiting_drain = 1'b1;
               drain_at = 0;
            end else begin
               row_at++;
            end
         end else begin
            col_at = c + 1;
         end
      end
      return gives;
   endfunction

   function automatic logic [PIX_W-1:0] rand_pixel();
      logic [PIX_W-1:0] p;
      for (int k = 0; k < NUM_CHAN; k++) begin
         case ($urandom_range(0, 7))
            0: p[CHAN_W*k +: CHAN_W] = '0;
            1: p[CHAN_W*k +: CHAN_W] = '1;
            default: p[CHAN_W*k +: CHAN_W] = CHAN_W'($urandom);
         endcase
      end
      return p;
   endfunction

   function automatic int unsigned idle_cycles();
      int unsigned pick;
      if (calm) return 0;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 16);
   endfunction

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #40_000_000;
      $display("FAIL cross_average_smudge_unit");
      $finish;
   end

   // Result side: check each transaction against the oldest expectation
   initial begin : result_side
      int unsigned  span;
      filtered_type want;
      span = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               $error("result with nothing expected: %h %h %h %h last %b", rsp_out_red,
                      rsp_out_green, rsp_out_blue, rsp_out_alpha, rsp_frame_last);
               fault_count++;
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_out_red !== want.red) begin
                  $error("out_red: expected %h, actual %h", want.red, rsp_out_red);
                  fault_count++;
               end
               if (rsp_out_green !== want.green) begin
                  $error("out_green: expected %h, actual %h", want.green, rsp_out_green);
                  fault_count++;
               end
               if (rsp_out_blue !== want.blue) begin
                  $error("out_blue: expected %h, actual %h", want.blue, rsp_out_blue);
                  fault_count++;
               end
               if (rsp_out_alpha !== want.alpha) begin
                  $error("out_alpha: expected %h, actual %h", want.alpha, rsp_out_alpha);
                  fault_count++;
               end
               if (rsp_frame_last !== want.last) begin
                  $error("frame_last: expected %b, actual %b", want.last, rsp_frame_last);
                  fault_count++;
               end
            end
         end
         if (span != 0) begin
            span--;
         end else if (calm || $urandom_range(0, 3) != 0) begin
            rsp_ready <= 1'b1;
            span = calm ? 0 : $urandom_range(0, 6);
         end else begin
            rsp_ready <= 1'b0;
            span = idle_cycles();
         end
      end
   end

   // Gap first, then hold the transaction until it is taken
   task automatic send_item(input logic cmd, input logic [PIX_W-1:0] pix,
                            output logic gives, output filtered_type got);
      int unsigned idle;
      idle = idle_cycles();
      if (idle != 0) begin
         req_valid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_cmd      <= cmd;
      req_in_red   <= pix[0*CHAN_W +: CHAN_W];
      req_in_green <= pix[1*CHAN_W +: CHAN_W];
      req_in_blue  <= pix[2*CHAN_W +: CHAN_W];
      req_in_alpha <= pix[3*CHAN_W +: CHAN_W];
      do @(posedge clock); while (!req_ready);
      gives = predict_smudge(cmd, pix, got);
   endtask

   task automatic feed(input logic cmd, input logic [PIX_W-1:0] pix);
      logic         gives;
      filtered_type got;
      send_item(cmd, pix, gives, got);
      if (gives) expected_pixels.push_back(got);
   endtask

   // Drop valid and let every outstanding result come out
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(input reg_index_type idx, input logic write,
                             input logic [DATA_W-1:0] wdata,
                             output logic [DATA_W-1:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= write;
      paddr   <= {idx, 2'b00};
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_size_reg(input int i);
      logic [DATA_W-1:0] back;
      csr_access(reg_index_type'(i), 1'b0, '0, back);
      if (back !== DATA_W'(size_q[i])) begin
         $error("register %0d: expected %h, actual %h", i, DATA_W'(size_q[i]), back);
         fault_count++;
      end
   endtask

   task automatic program_size(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
      logic [SIZE_W-1:0] want [2];
      logic [DATA_W-1:0] unused;
      want[REG_FRAME_WIDTH]  = w;
      want[REG_FRAME_HEIGHT] = h;
      for (int i = 0; i < 2; i++) begin
         if (want[i] != size_q[i]) begin
            csr_access(reg_index_type'(i), 1'b1, DATA_W'(want[i]), unused);
            size_q[i] = want[i];
            check_size_reg(i);
         end
      end
   endtask

   task automatic run_frame(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h,
                            input bit may_shrink);
      int unsigned cut;
      int unsigned sent;
      int unsigned area;
      if (w != size_q[REG_FRAME_WIDTH] || h != size_q[REG_FRAME_HEIGHT]) begin
         wait_drained();
         program_size(w, h);
      end
      area = int'(w) * int'(h);
      cut = 0;
      if (may_shrink && area > 3 && $urandom_range(0, 4) == 0)
         cut = $urandom_range(1, area - 1);
      sent = 0;
      while (!awaiting_drain) begin
         // shrink a size mid-frame; only shrinking keeps every line read on written data
         if (cut != 0 && sent == cut) begin
            wait_drained();
            if ($urandom_range(0, 1) == 0)
               program_size(SIZE_W'($urandom_range(1,
                  clamp_size(size_q[REG_FRAME_WIDTH], MAX_WIDTH))), size_q[REG_FRAME_HEIGHT]);
            else
               program_size(size_q[REG_FRAME_WIDTH], SIZE_W'($urandom_range(1,
                  clamp_size(size_q[REG_FRAME_HEIGHT], MAX_HEIGHT))));
         end
         if ($urandom_range(0, 24) == 0) feed(CMD_DRAIN, rand_pixel());
         feed(CMD_PIXEL, rand_pixel());
         sent++;
         if (may_shrink) random_items++;
      end
      if ($urandom_range(0, 2) == 0) feed(CMD_PIXEL, rand_pixel());
      while (awaiting_drain) begin
         feed(CMD_DRAIN, rand_pixel());
         if (may_shrink) random_items++;
      end
   endtask

   initial begin : stimulus
      script_row_type    line;
      logic              gives;
      filtered_type      got;
      int unsigned       frame_no;
      int unsigned       next_extreme;
      logic [SIZE_W-1:0] w;
      logic [SIZE_W-1:0] h;
      size_q[REG_FRAME_WIDTH]  = FRAME_WIDTH_RESET;
      size_q[REG_FRAME_HEIGHT] = FRAME_HEIGHT_RESET;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < 2; i++) check_size_reg(i);

      foreach (directed_script[i]) begin
         line = directed_script[i];
         if (line.w != size_q[REG_FRAME_WIDTH] || line.h != size_q[REG_FRAME_HEIGHT]) begin
            wait_drained();
            program_size(line.w, line.h);
         end
         send_item(line.cmd, line.pix, gives, got);
         if (line.typed) begin
            gives = line.gives;
            got = split_pixel(line.want, line.want_last);
         end
         if (gives) expected_pixels.push_back(got);
      end

      frame_no = 0;
      next_extreme = 0;
      while (random_items < RANDOM_ITEMS || next_extreme < NUM_EXTREMES) begin
         calm = ($urandom_range(0, 5) == 0);
         if (frame_no % 6 == 5 && next_extreme < NUM_EXTREMES) begin
            run_frame(extreme_sizes[next_extreme][0], extreme_sizes[next_extreme][1], 1'b0);
            next_extreme++;
         end else begin
            w = ($urandom_range(0, 99) < 85) ? SIZE_W'($urandom_range(1, 10))
                                             : SIZE_W'($urandom_range(11, 48));
            h = ($urandom_range(0, 99) < 85) ? SIZE_W'($urandom_range(1, 6))
                                             : SIZE_W'($urandom_range(7, 16));
            run_frame(w, h, 1'b1);
         end
         frame_no++;
      end

      calm = 1'b0;
      wait_drained();
      if (fault_count == 0)
         $display("PASS cross_average_smudge_unit");
      else
         $display("FAIL cross_average_smudge_unit");
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+design
design/csm_pkg.sv
design/csm_ram.sv
design/csm_front.sv
design/csm_queue.sv
design/csm_back.sv
design/cross_average_smudge_unit.sv
design/csm_checker.sv
bench/tb_cross_average_smudge_unit.sv
